>>> hw/rtl/ebaf_pkg.sv
// Package for the event background-activity filter.
// Holds field widths, register indexes and the structs shared by the front end, back end and top level.
// No dependencies.
package ebaf_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned TimeW   = 47;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RadW    = 4;
  localparam int unsigned DimW    = 11;

  localparam logic [CfgIdxW-1:0] CfgWindow    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRefract   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRadius    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWidth     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHeight    = 3'd5;

  typedef struct packed {
    logic [31:0] window;
    logic [7:0]  thr;
    logic [31:0] refr;
    logic [2:0]  radius;
    logic [9:0]  width;
    logic [9:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [TimeW-1:0]  t;
  } evt_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [TimeW-1:0]  t;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y1;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

>>> hw/rtl/ebaf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ebaf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/ebaf_fifo.sv
// Small register FIFO used between the front and back and on the result side.
// No dependencies.
module ebaf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/ebaf_front.sv
// Front end: drops events outside the active area and computes the clipped
// neighbourhood box. Depends on ebaf_pkg.
module ebaf_front #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic          accept_i,
  input  ebaf_pkg::evt_t evt_i,
  input  ebaf_pkg::cfg_t cfg_i,
  output logic          cmd_push_o,
  output ebaf_pkg::cmd_t cmd_o
);
  import ebaf_pkg::*;

  logic [DimW-1:0]   w_eff, h_eff, w_last, h_last, xr, yr;
  logic [RadW-1:0]   rad;
  logic [CoordW-1:0] rad_ext;
  logic              in_area;

  always_comb begin
    w_eff = ({1'b0, cfg_i.width} > DimW'(MAX_WIDTH)) ? DimW'(MAX_WIDTH)
                                                      : {1'b0, cfg_i.width};
    h_eff = ({1'b0, cfg_i.height} > DimW'(MAX_HEIGHT)) ? DimW'(MAX_HEIGHT)
                                                        : {1'b0, cfg_i.height};
    rad = ({1'b0, cfg_i.radius} > RadW'(MAX_RADIUS)) ? RadW'(MAX_RADIUS)
                                                     : {1'b0, cfg_i.radius};
    rad_ext = CoordW'(rad);
    in_area = ({1'b0, evt_i.x} < w_eff) && ({1'b0, evt_i.y} < h_eff);
    w_last  = w_eff - 1'b1;
    h_last  = h_eff - 1'b1;
    xr      = {1'b0, evt_i.x} + DimW'(rad);
    yr      = {1'b0, evt_i.y} + DimW'(rad);

    cmd_o.x  = evt_i.x;
    cmd_o.y  = evt_i.y;
    cmd_o.t  = evt_i.t;
    cmd_o.x0 = (evt_i.x > rad_ext) ? evt_i.x - rad_ext : '0;
    cmd_o.y0 = (evt_i.y > rad_ext) ? evt_i.y - rad_ext : '0;
    cmd_o.x1 = (xr < w_last) ? xr[CoordW-1:0] : w_last[CoordW-1:0];
    cmd_o.y1 = (yr < h_last) ? yr[CoordW-1:0] : h_last[CoordW-1:0];
  end

  assign cmd_push_o = accept_i && in_area;

endmodule

>>> hw/rtl/ebaf_back.sv
// Back end: clears the pixel memory after reset, then for each event checks the
// refractory interval, scans the neighbourhood and writes back. Depends on
// ebaf_pkg and ebaf_ram.
module ebaf_back #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebaf_pkg::cfg_t      cfg_i,
  input  logic                cmd_empty_i,
  input  ebaf_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output ebaf_pkg::evt_t      res_o,
  output ebaf_pkg::back_stat_t stat_o
);
  import ebaf_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int unsigned WordW = TimeW + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_OWN  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_LAST = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AW:0]       clr_q, clr_d;
  cmd_t              cur_q, cur_d;
  logic [CoordW-1:0] xx_q, xx_d, yy_q, yy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              scan_vld_q, scan_vld_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WordW-1:0]  ram_wdata, ram_rdata;
  logic [TimeW:0]    diff;
  logic              refr_hit, win_hit, pass;
  logic [7:0]        thr_eff;

  function automatic logic [AW-1:0] pix_addr(input logic [CoordW-1:0] x,
                                             input logic [CoordW-1:0] y);
    pix_addr = AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
  endfunction

  ebaf_ram #(
    .WIDTH (WordW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Signed difference between the event time and the stored time.
  assign diff     = {1'b0, cur_q.t} - {1'b0, ram_rdata[TimeW-1:0]};
  assign refr_hit = ram_rdata[TimeW] &&
                    ($signed(diff) < $signed({{(TimeW + 1 - 32){1'b0}}, cfg_i.refr}));
  assign win_hit  = ram_rdata[TimeW] &&
                    ($signed(diff) <= $signed({{(TimeW + 1 - 32){1'b0}}, cfg_i.window}));
  assign thr_eff  = (cfg_i.thr == '0) ? 8'd1 : cfg_i.thr;
  assign pass     = 16'(cnt_q) >= 16'(thr_eff);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    xx_d       = xx_q;
    yy_d       = yy_q;
    cnt_d      = cnt_q;
    scan_vld_d = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = pix_addr(cur_q.x, cur_q.y);
    ram_wdata  = {1'b1, cur_q.t};
    ram_raddr  = pix_addr(cur_q.x, cur_q.y);
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;

    if (scan_vld_q && win_hit) begin
      cnt_d = cnt_q + 1'b1;
    end

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (AW + 1)'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          ram_re    = 1'b1;
          ram_raddr = pix_addr(cmd_i.x, cmd_i.y);
          state_d   = S_OWN;
        end
      end
      S_OWN: begin
        if (refr_hit) begin
          ram_we  = 1'b1;
          state_d = S_IDLE;
        end else begin
          xx_d    = cur_q.x0;
          yy_d    = cur_q.y0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re     = 1'b1;
        ram_raddr  = pix_addr(xx_q, yy_q);
        scan_vld_d = 1'b1;
        if (xx_q == cur_q.x1) begin
          xx_d = cur_q.x0;
          if (yy_q == cur_q.y1) begin
            state_d = S_LAST;
          end else begin
            yy_d = yy_q + 1'b1;
          end
        end else begin
          xx_d = xx_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        ram_we     = 1'b1;
        res_push_o = pass;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      scan_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      scan_vld_q <= scan_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    xx_q  <= xx_d;
    yy_q  <= yy_d;
    cnt_q <= cnt_d;
  end

  assign res_o.x         = cur_q.x;
  assign res_o.y         = cur_q.y;
  assign res_o.t         = cur_q.t;
  assign stat_o.clearing = (state_q == S_CLR);
  assign stat_o.busy     = (state_q != S_IDLE) && (state_q != S_CLR);

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !cmd_pop_o)
    else $error("command taken during memory clear");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("memory read and write in one cycle");
  a_pop_to_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == S_OWN))
    else $error("own pixel check skipped");
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

endmodule

>>> hw/rtl/event_background_activity_filter.sv
// Top level of the event background-activity filter.
// Depends on ebaf_pkg, ebaf_front, ebaf_fifo and ebaf_back.
//
// Events enter through a queue-style port: a beat is taken when push is high
// and full is low. Passed events leave the same way: the oldest result sits on
// out_x_o, out_y_o and out_time_o while empty is low and is taken when pop is
// high. Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i with no wait; write them only while the filter is idle.
//
// After reset the pixel memory is swept clear, one pixel per cycle; full stays
// high during that sweep. Each event then gets an own-pixel check in the back
// end; unless it is a refractory drop, the back end scans its clipped
// neighbourhood box (9 pixels at radius one), walking it one pixel per cycle
// through the single read port of the pixel memory, and then writes back.
// Events dropped by position cost nothing in the back end, and refractory drops
// leave it right after the own-pixel check.
// A two-beat queue lets the front accept events while the back end works, and
// a two-beat result queue absorbs a stalled receiver; the back end only starts
// an event when the result queue has room.
module event_background_activity_filter #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [ebaf_pkg::CoordW-1:0]      pixel_x_i,
  input  logic [ebaf_pkg::CoordW-1:0]      pixel_y_i,
  input  logic [ebaf_pkg::TimeW-1:0]       event_time_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [ebaf_pkg::CoordW-1:0]      out_x_o,
  output logic [ebaf_pkg::CoordW-1:0]      out_y_o,
  output logic [ebaf_pkg::TimeW-1:0]       out_time_o,
  input  logic                             cfg_we_i,
  input  logic [ebaf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ebaf_pkg::CfgW-1:0]        cfg_data_i
);
  import ebaf_pkg::*;

  cfg_t       cfg_q;
  evt_t       evt_in, res_in, res_out;
  cmd_t       cmd_in, cmd_out;
  logic       accept, cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic       res_push, res_full;
  back_stat_t stat;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= 32'd10000;
      cfg_q.thr    <= 8'd1;
      cfg_q.refr   <= 32'd0;
      cfg_q.radius <= 3'd1;
      cfg_q.width  <= 10'd346;
      cfg_q.height <= 10'd260;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindow:    cfg_q.window <= cfg_data_i;
        CfgThreshold: cfg_q.thr    <= cfg_data_i[7:0];
        CfgRefract:   cfg_q.refr   <= cfg_data_i;
        CfgRadius:    cfg_q.radius <= cfg_data_i[2:0];
        CfgWidth:     cfg_q.width  <= cfg_data_i[9:0];
        CfgHeight:    cfg_q.height <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  // The input side reports full while the command queue is full or while the
  // pixel memory is still being cleared.
  assign full     = cmd_full || stat.clearing;
  assign accept   = push && !full;
  assign evt_in.x = pixel_x_i;
  assign evt_in.y = pixel_y_i;
  assign evt_in.t = event_time_i;

  ebaf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .accept_i   (accept),
    .evt_i      (evt_in),
    .cfg_i      (cfg_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  ebaf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  ebaf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .stat_o      (stat)
  );

  ebaf_fifo #(
    .WIDTH ($bits(evt_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_x_o    = res_out.x;
  assign out_y_o    = res_out.y;
  assign out_time_o = res_out.t;

endmodule
